[hw/rtl/wvma_pkg.sv]
// types, constants and codes for the weighted voxel mean accumulator
// used by weighted_voxel_mean_accumulator and its checker; depends on nothing

package wvma_pkg;

    localparam int VOXEL_COUNT = 65536;
    localparam int VOX_W       = 16;
    localparam int ADDR_W      = $clog2(VOXEL_COUNT);
    localparam int SAMPLE_W    = 16;
    localparam int Q88_W       = 16;
    localparam int SUM_W       = 41;
    localparam int TOTAL_W     = 26;
    localparam int PROD_W      = (SAMPLE_W - 1) + Q88_W;
    localparam int SUM_LO_W    = 21;
    localparam int SUM_HI_W    = SUM_W - SUM_LO_W;
    localparam int MUL_P_W     = Q88_W + SUM_LO_W;
    localparam int NUM_W       = 57;
    localparam int MEAN_W      = 32;
    localparam int DIV_CNT_W   = $clog2(NUM_W);
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [Q88_W-1:0]  WEIGHT_RESET = 16'd256;
    localparam logic [Q88_W-1:0]  SCALE_RESET  = 16'd256;
    localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX     = 32'h7FFF_FFFF;
    localparam logic [MEAN_W-1:0] NO_DATA_MEAN = 32'hFFFF_FF00;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'b1;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_FINAL = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode                    opcode;
        logic [VOX_W-1:0]           voxel_index;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [VOX_W-1:0]         result_voxel;
        logic signed [MEAN_W-1:0] mean_value;
        logic                     no_data;
    } t_out_item;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TOTAL_W-1:0] total;
    } t_entry;

endpackage

[hw/rtl/weighted_voxel_mean_accumulator.sv]
// per-voxel weighted mean: one voxel store memory, read-modify-write, radix-2 divider
// depends on wvma_pkg
//
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_stall  i_in_data  (wvma_pkg::t_in_item)
//  out       output     o_out_valid/i_out_stall o_out_data (wvma_pkg::t_out_item)
//  cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
// accumulate reads, then modifies and writes back; a padding sample is dropped;
// clear writes zeros when taken; opcode 3 does nothing.
// finalize: read, two 16x21 partial products, 57 divider steps, result load;
// an empty voxel: read, result load.
// after reset a clearing pass writes zeros to all 65536 entries, one a cycle; input stalls.
// the output register lets later items in while a result waits; a finalize holds in its
// last cycle until the previous result is taken.

module weighted_voxel_mean_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wvma_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wvma_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [wvma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wvma_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [wvma_pkg::ADDR_W-1:0] INIT_LAST =
        wvma_pkg::ADDR_W'(wvma_pkg::VOXEL_COUNT - 1);
    localparam logic [wvma_pkg::DIV_CNT_W-1:0] DIV_LAST =
        wvma_pkg::DIV_CNT_W'(wvma_pkg::NUM_W - 1);

    wvma_pkg::t_entry r_mem [wvma_pkg::VOXEL_COUNT];
    wvma_pkg::t_entry r_mem_q;

    wvma_pkg::t_state r_state, n_state;
    logic [wvma_pkg::ADDR_W-1:0]    r_init_addr;
    logic [wvma_pkg::Q88_W-1:0]     r_image_weight;
    logic [wvma_pkg::Q88_W-1:0]     r_output_scale;
    logic                           r_out_valid;
    wvma_pkg::t_out_item            r_out_data;

    wvma_pkg::t_in_item             r_item;
    logic                           r_in_range;
    logic [wvma_pkg::PROD_W-1:0]    r_prod;
    logic                           r_nodata;
    logic [wvma_pkg::NUM_W-1:0]     r_acc;
    logic [wvma_pkg::NUM_W-1:0]     r_num;
    logic [wvma_pkg::TOTAL_W-1:0]   r_rem;
    logic [wvma_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic                           w_in_ready;
    logic                           w_in_xfer;
    logic                           w_in_range;
    logic                           w_out_free;
    logic                           w_out_load;
    logic                           w_no_data;
    logic                           w_mem_we;
    logic [wvma_pkg::ADDR_W-1:0]    w_mem_wa;
    wvma_pkg::t_entry               w_mem_wd;
    wvma_pkg::t_entry               w_acc_entry;
    logic [wvma_pkg::PROD_W-1:0]    w_prod;
    logic [wvma_pkg::SUM_W:0]       w_sum_add;
    logic [wvma_pkg::TOTAL_W:0]     w_tot_add;
    logic [wvma_pkg::SUM_LO_W-1:0]  w_mul_b;
    logic [wvma_pkg::MUL_P_W-1:0]   w_mul_p;
    logic [wvma_pkg::TOTAL_W:0]     w_rem_sh;
    logic                           w_rem_ge;
    logic [wvma_pkg::MEAN_W-1:0]    w_mean;

    assign w_in_xfer  = i_in_valid && w_in_ready;
    assign w_in_range = {1'b0, i_in_data.voxel_index} <
                        (wvma_pkg::VOX_W + 1)'(wvma_pkg::VOXEL_COUNT);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_no_data  = !r_in_range || (r_mem_q.total == '0);

    // sample is known non-negative when the product is used
    assign w_prod = wvma_pkg::PROD_W'(i_in_data.sample_value[wvma_pkg::SAMPLE_W-2:0]) *
                    wvma_pkg::PROD_W'(r_image_weight);

    // saturating accumulate
    assign w_sum_add = {1'b0, r_mem_q.sum} + (wvma_pkg::SUM_W + 1)'(r_prod);
    assign w_tot_add = {1'b0, r_mem_q.total} + (wvma_pkg::TOTAL_W + 1)'(r_image_weight);
    assign w_acc_entry.sum   = w_sum_add[wvma_pkg::SUM_W] ? wvma_pkg::SUM_MAX
                                                          : w_sum_add[wvma_pkg::SUM_W-1:0];
    assign w_acc_entry.total = w_tot_add[wvma_pkg::TOTAL_W] ? wvma_pkg::TOTAL_MAX
                                                            : w_tot_add[wvma_pkg::TOTAL_W-1:0];

    // one shared multiplier, low then high slice of the sum
    assign w_mul_b = (r_state == wvma_pkg::S_MUL_LO) ?
                     r_mem_q.sum[wvma_pkg::SUM_LO_W-1:0] :
                     wvma_pkg::SUM_LO_W'(r_mem_q.sum[wvma_pkg::SUM_W-1:wvma_pkg::SUM_LO_W]);
    assign w_mul_p = wvma_pkg::MUL_P_W'(r_output_scale) * wvma_pkg::MUL_P_W'(w_mul_b);

    // restoring divider step
    assign w_rem_sh = {r_rem, r_num[wvma_pkg::NUM_W-1]};
    assign w_rem_ge = w_rem_sh >= {1'b0, r_mem_q.total};

    assign w_mean = (|r_num[wvma_pkg::NUM_W-1:wvma_pkg::MEAN_W-1]) ? wvma_pkg::MEAN_MAX :
                    {1'b0, r_num[wvma_pkg::MEAN_W-2:0]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wvma_pkg::S_INIT: begin
                if (r_init_addr == INIT_LAST) n_state = wvma_pkg::S_IDLE;
            end
            wvma_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    case (i_in_data.opcode)
                        wvma_pkg::OP_ACCUM: begin
                            if (w_in_range && !i_in_data.sample_value[wvma_pkg::SAMPLE_W-1])
                                n_state = wvma_pkg::S_READ;
                        end
                        wvma_pkg::OP_FINAL: n_state = wvma_pkg::S_READ;
                        default: ;
                    endcase
                end
            end
            wvma_pkg::S_READ: begin
                if (r_item.opcode == wvma_pkg::OP_FINAL) begin
                    n_state = w_no_data ? wvma_pkg::S_DONE : wvma_pkg::S_MUL_LO;
                end else begin
                    n_state = wvma_pkg::S_IDLE;
                end
            end
            wvma_pkg::S_MUL_LO: n_state = wvma_pkg::S_MUL_HI;
            wvma_pkg::S_MUL_HI: n_state = wvma_pkg::S_DIV;
            wvma_pkg::S_DIV: begin
                if (r_div_cnt == DIV_LAST) n_state = wvma_pkg::S_DONE;
            end
            wvma_pkg::S_DONE: begin
                if (w_out_free) n_state = wvma_pkg::S_IDLE;
            end
            default: n_state = wvma_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_wa   = r_item.voxel_index[wvma_pkg::ADDR_W-1:0];
        w_mem_wd   = '0;
        case (r_state)
            wvma_pkg::S_INIT: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_init_addr;
            end
            wvma_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid && i_in_data.opcode == wvma_pkg::OP_CLEAR && w_in_range) begin
                    w_mem_we = 1'b1;
                    w_mem_wa = i_in_data.voxel_index[wvma_pkg::ADDR_W-1:0];
                end
            end
            wvma_pkg::S_READ: begin
                if (r_item.opcode == wvma_pkg::OP_ACCUM) begin
                    w_mem_we = 1'b1;
                    w_mem_wd = w_acc_entry;
                end
            end
            wvma_pkg::S_DONE: w_out_load = w_out_free;
            default: ;
        endcase
    end

    assign o_in_stall  = !w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // voxel store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_wa] <= w_mem_wd;
        if (w_in_xfer) r_mem_q <= r_mem[i_in_data.voxel_index[wvma_pkg::ADDR_W-1:0]];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= wvma_pkg::S_INIT;
            r_init_addr    <= '0;
            r_out_valid    <= 1'b0;
            r_image_weight <= wvma_pkg::WEIGHT_RESET;
            r_output_scale <= wvma_pkg::SCALE_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == wvma_pkg::S_INIT) r_init_addr <= r_init_addr + 1'b1;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wvma_pkg::CFG_IMAGE_WEIGHT: r_image_weight <= i_cfg_data;
                    wvma_pkg::CFG_OUTPUT_SCALE: r_output_scale <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item     <= i_in_data;
            r_in_range <= w_in_range;
            r_prod     <= w_prod;
        end
        case (r_state)
            wvma_pkg::S_READ: r_nodata <= w_no_data;
            wvma_pkg::S_MUL_LO: begin
                r_acc <= wvma_pkg::NUM_W'(w_mul_p) +
                         wvma_pkg::NUM_W'(r_mem_q.total[wvma_pkg::TOTAL_W-1:1]);
            end
            wvma_pkg::S_MUL_HI: begin
                r_num     <= r_acc + wvma_pkg::NUM_W'({w_mul_p, {wvma_pkg::SUM_LO_W{1'b0}}});
                r_rem     <= '0;
                r_div_cnt <= '0;
            end
            wvma_pkg::S_DIV: begin
                r_rem     <= w_rem_ge ?
                             wvma_pkg::TOTAL_W'(w_rem_sh - {1'b0, r_mem_q.total}) :
                             w_rem_sh[wvma_pkg::TOTAL_W-1:0];
                r_num     <= {r_num[wvma_pkg::NUM_W-2:0], w_rem_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_data.result_voxel <= r_item.voxel_index;
            r_out_data.mean_value   <= r_nodata ? wvma_pkg::NO_DATA_MEAN : w_mean;
            r_out_data.no_data      <= r_nodata;
        end
    end

endmodule

[hw/rtl/wvma_checker.sv]
// port-level checks for weighted_voxel_mean_accumulator, attached by bind
// depends on wvma_pkg

module wvma_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  wvma_pkg::t_out_item             o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // the clearing pass follows every reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input open or result shown right after reset");

    a_no_data_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_data |->
            o_out_data.mean_value == wvma_pkg::NO_DATA_MEAN)
        else $error("no-data result with wrong mean");

    a_mean_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.no_data |-> !o_out_data.mean_value[wvma_pkg::MEAN_W-1])
        else $error("negative mean with data present");

endmodule

bind weighted_voxel_mean_accumulator wvma_checker u_wvma_checker (.*);
